// ===== hw/rtl/pma_pkg.sv =====
// ----------------------------------------------------------------------------
// pma_pkg
// Shared types and constants for the Potts Metropolis step engine.
// ----------------------------------------------------------------------------
package pma_pkg;

	localparam int MAX_SITES_DEF   = 16;
	localparam int SPIN_STATES_DEF = 30;
	localparam logic [4:0] ACTIVE_RESET = 5'd10;

	localparam logic [2:0] KIND_LOAD   = 3'd0;
	localparam logic [2:0] KIND_SET    = 3'd1;
	localparam logic [2:0] KIND_ENERGY = 3'd2;
	localparam logic [2:0] KIND_TRIAL  = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	localparam logic signed [23:0] E_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] E_MIN = -24'sh800000;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPIN,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  site_a;
		logic [3:0]  site_b;
		logic signed [15:0] coupling;
		logic [4:0]  spin_label;
		logic [22:0] accept_margin;
		logic        take_sample;
	} item_t;

	typedef struct packed {
		logic signed [23:0] energy;
		logic        accepted;
		logic signed [39:0] energy_sum;
		logic [61:0] energy_square_sum;
		logic [15:0] sample_count;
	} result_t;

	function automatic logic signed [23:0] sat_energy(input logic signed [31:0] v);
		if (v > 32'(E_MAX)) return E_MAX;
		if (v < 32'(E_MIN)) return E_MIN;
		return v[23:0];
	endfunction

endpackage

// ===== hw/rtl/pma_if.sv =====
// ----------------------------------------------------------------------------
// pma_if
// Valid/ready channel interfaces for items, results and configuration.
// ----------------------------------------------------------------------------
interface pma_item_if;
	logic valid;
	logic ready;
	pma_pkg::item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pma_result_if;
	logic valid;
	logic ready;
	pma_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pma_cfg_if;
	logic valid;
	logic ready;
	logic [4:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pma_stats.sv =====
// ----------------------------------------------------------------------------
// pma_stats
// Sample accumulators: energy sum, squared sum and saturating count.
// ----------------------------------------------------------------------------
module pma_stats (
	input  logic clk,
	input  logic arst_n,
	input  logic sample,
	input  logic clear,
	input  logic signed [23:0] energy,
	output logic signed [39:0] energy_sum,
	output logic [62:0] square_sum,
	output logic [15:0] count
);
	logic [23:0] mag;
	logic [47:0] sq;

	assign mag = energy[23] ? 24'(-energy) : 24'(energy);
	assign sq  = 48'(mag) * 48'(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_sum <= '0;
			square_sum <= '0;
			count      <= '0;
		end else if (clear) begin
			energy_sum <= '0;
			square_sum <= '0;
			count      <= '0;
		end else if (sample && count != pma_pkg::COUNT_MAX) begin
			energy_sum <= energy_sum + 40'(energy);
			square_sum <= square_sum + 63'(sq);
			count      <= count + 16'd1;
		end
	end
endmodule

// ===== hw/rtl/pma_core.sv =====
// ----------------------------------------------------------------------------
// pma_core
// Coupling and spin memories with the sequencer that scans them.
// ----------------------------------------------------------------------------
module pma_core #(
	parameter int SPIN_STATES = pma_pkg::SPIN_STATES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [4:0] active_sites,
	input  logic in_valid,
	output logic in_ready,
	input  pma_pkg::item_t item,
	output logic res_valid,
	input  logic res_ready,
	output pma_pkg::result_t res
);
	localparam int MAX_SITES = pma_pkg::MAX_SITES_DEF;
	localparam int SW = $clog2(MAX_SITES);
	localparam int AW = 2 * SW;

	logic signed [15:0] cmem [MAX_SITES*MAX_SITES];
	logic [4:0] smem [MAX_SITES];

	pma_pkg::state_t state_q, state_d;
	pma_pkg::item_t it_q;
	logic [SW-1:0] i_q, j_q;
	logic [SW:0] n_q;
	logic [4:0] old_q;
	logic signed [31:0] acc_q;
	logic signed [23:0] energy_q;
	logic accepted_q;
	logic rd_en_s1;
	logic [SW-1:0] rj_s1;

	logic [AW-1:0] caddr;
	logic signed [15:0] crd;
	logic [4:0] srd_i, srd_j;
	logic [4:0] label_i, label_j;

	logic label_ok, sample, clear;
	logic signed [39:0] esum;
	logic [62:0] ssum;
	logic [15:0] cnt;
	logic [SW:0] eff;

	assign eff = (active_sites < 5'd2) ? (SW+1)'(2) :
		((32'(active_sites) > MAX_SITES) ? (SW+1)'(MAX_SITES) : (SW+1)'(active_sites));
	assign label_ok = item.spin_label >= 5'd1 && 32'(item.spin_label) <= SPIN_STATES;
	assign in_ready = state_q == pma_pkg::ST_IDLE;

	wire in_fire = in_valid && in_ready;
	wire scanning = state_q == pma_pkg::ST_SCAN;
	wire trial = it_q.kind == pma_pkg::KIND_TRIAL;

	// Lower-triangle address for the pair being scanned.
	logic [SW-1:0] pa, pb;
	always_comb begin
		if (trial) begin
			pa = (it_q.site_a > j_q) ? it_q.site_a[SW-1:0] : j_q;
			pb = (it_q.site_a > j_q) ? j_q : it_q.site_a[SW-1:0];
		end else begin
			pa = i_q;
			pb = j_q;
		end
	end
	assign caddr = {pa, pb};

	logic signed [31:0] term;
	always_comb begin
		term = '0;
		if (trial) begin
			if (rj_s1 != it_q.site_a[SW-1:0]) begin
				if (label_j == it_q.spin_label) term = term - 32'(crd);
				if (label_j == old_q) term = term + 32'(crd);
			end
		end else if (label_i == label_j) begin
			term = -32'(crd);
		end
	end

	wire signed [31:0] margin = 32'(it_q.accept_margin);
	wire accept_now = (acc_q <= 0) || (acc_q < margin);

	always_ff @(posedge clk) begin
		if (in_fire && item.kind == pma_pkg::KIND_LOAD &&
			32'(item.site_a) < MAX_SITES && item.site_b < item.site_a)
			cmem[{item.site_a[SW-1:0], item.site_b[SW-1:0]}] <= item.coupling;
		if (in_fire && item.kind == pma_pkg::KIND_SET &&
			32'(item.site_a) < MAX_SITES && label_ok)
			smem[item.site_a[SW-1:0]] <= item.spin_label;
		if (state_q == pma_pkg::ST_DONE && trial && accept_now)
			smem[it_q.site_a[SW-1:0]] <= it_q.spin_label;
		crd   <= cmem[caddr];
		srd_i <= smem[trial ? it_q.site_a[SW-1:0] : i_q];
		srd_j <= smem[j_q];
	end
	assign label_i = srd_i;
	assign label_j = srd_j;

	// Sampling uses the energy before the trial changes it.
	assign sample = in_fire && item.kind == pma_pkg::KIND_TRIAL && item.take_sample;
	assign clear  = res_valid && res_ready && it_q.kind == pma_pkg::KIND_CLEAR;

	pma_stats u_stats (
		.clk(clk), .arst_n(arst_n), .sample(sample), .clear(clear),
		.energy(energy_q), .energy_sum(esum), .square_sum(ssum), .count(cnt)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pma_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (item.kind == pma_pkg::KIND_ENERGY) state_d = pma_pkg::ST_SCAN;
					else if (item.kind == pma_pkg::KIND_TRIAL &&
						32'(item.site_a) < 32'(eff) && label_ok) state_d = pma_pkg::ST_SPIN;
					else state_d = pma_pkg::ST_OUT;
				end
			end
			pma_pkg::ST_SPIN:  state_d = pma_pkg::ST_SCAN;
			pma_pkg::ST_SCAN: begin
				if (trial ? (32'(j_q) == 32'(n_q) - 1) :
					(32'(i_q) == 32'(n_q) - 1 && 32'(j_q) == 32'(i_q) - 1))
					state_d = pma_pkg::ST_DRAIN;
			end
			pma_pkg::ST_DRAIN: state_d = pma_pkg::ST_DONE;
			pma_pkg::ST_DONE:  state_d = pma_pkg::ST_OUT;
			pma_pkg::ST_OUT:   if (res_ready) state_d = pma_pkg::ST_IDLE;
			default:           state_d = pma_pkg::ST_IDLE;
		endcase
	end

	// The last pair's term lands during the drain cycle, so the decision waits
	// for the done cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pma_pkg::ST_IDLE;
			energy_q   <= '0;
			accepted_q <= 1'b0;
			rd_en_s1   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_en_s1 <= scanning;
			if (in_fire) accepted_q <= 1'b0;
			if (state_q == pma_pkg::ST_DONE) begin
				if (!trial) energy_q <= pma_pkg::sat_energy(acc_q);
				else begin
					accepted_q <= accept_now;
					if (accept_now)
						energy_q <= pma_pkg::sat_energy(32'(energy_q) + acc_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rj_s1 <= j_q;
		if (in_fire) begin
			it_q  <= item;
			n_q   <= eff;
			acc_q <= '0;
			i_q   <= (SW)'(1);
			j_q   <= '0;
		end
		// The spin of the trial site is read during the spin cycle.
		if (scanning && j_q == '0) old_q <= srd_i;
		if (rd_en_s1) acc_q <= acc_q + term;
		if (scanning) begin
			if (trial) j_q <= j_q + 1'b1;
			else if (j_q == i_q - 1'b1) begin
				i_q <= i_q + 1'b1;
				j_q <= '0;
			end else j_q <= j_q + 1'b1;
		end
	end

	assign res_valid = state_q == pma_pkg::ST_OUT;
	always_comb begin
		res.energy            = energy_q;
		res.accepted          = accepted_q;
		res.energy_sum        = esum;
		res.energy_square_sum = ssum[61:0];
		res.sample_count      = cnt;
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid) else $error("ready while result pending");
	a_acc_trial: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.accepted) |-> trial) else $error("accept outside trial");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid && $stable(energy_q))
		else $error("result changed while stalled");
endmodule

// ===== hw/rtl/potts_metropolis_anneal_step_top.sv =====
// ----------------------------------------------------------------------------
// potts_metropolis_anneal_step_top
// Potts model Metropolis engine with coupling and spin memories.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  in_ch   | in  | kind, sites, coupling, label, margin, sample flag
//  out_ch  | out | energy, accepted, sums, count
//  cfg_ch  | in  | active_sites
// Loads, sets and clears go straight to the output state. A trial scans the
// n active sites and an energy recompute the n*(n-1)/2 pairs among them, one
// coupling memory read per pair. Reset is asynchronous, active low, and needs
// no clearing pass. A stalled result holds the block in its output state.
module potts_metropolis_anneal_step_top #(
	parameter int SPIN_STATES = pma_pkg::SPIN_STATES_DEF
) (
	input logic clk,
	input logic arst_n,
	pma_item_if.sink     in_ch,
	pma_result_if.source out_ch,
	pma_cfg_if.sink      cfg_ch
);
	logic [4:0] active_q;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) active_q <= pma_pkg::ACTIVE_RESET;
		else if (cfg_ch.valid) active_q <= cfg_ch.data;
	end

	pma_core #(.SPIN_STATES(SPIN_STATES)) u_core (
		.clk(clk), .arst_n(arst_n), .active_sites(active_q),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .item(in_ch.data),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
	);
endmodule
